[src/b64e_pkg.sv]
// Shared types and constants for the Base64 stream encoder.
// Holds the queued group record and the sextet-to-character function.
// No dependencies.
package b64e_pkg;

   // Character emitted in place of a missing sextet.
   localparam logic [7:0] PadChar = 8'h3D;

   // Index of the last character of a group.
   localparam logic [1:0] LastIdx = 2'd3;

   // Number of entries in the queue between the front and the back.
   localparam int QueueDepth = 2;

   // One group of up to three bytes, with the count of real bytes (1 to 3).
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] present;
   } group_type;

   // Queue status as seen by the producer.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Maps a sextet to its character in the standard alphabet.
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] c;
      begin
         if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
         end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
         end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
         end else if (v == 6'd62) begin
            c = 8'h2B;
         end else begin
            c = 8'h2F;
         end
         return c;
      end
   endfunction

endpackage

[src/b64e_front.sv]
// Front part of the Base64 encoder: accepts request bytes and builds groups.
// Holds up to two bytes and pushes a finished group into the queue.
// Depends on b64e_pkg.
module b64e_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_is_final,
   input  b64e_pkg::queue_status_type  q_status,
   output logic                        q_push,
   output b64e_pkg::group_type         q_group
);

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [1:0] cnt;
   logic       accept;
   logic       closes;

   // Stall whenever the queue cannot take another group.
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // A count of three cannot happen; treat it as two.
   assign cnt    = (held_count_ff == 2'd3) ? 2'd2 : held_count_ff;
   assign closes = (cnt == 2'd2) || req_is_final;
   assign q_push = accept && closes;

   // Assemble the group from held bytes and the incoming byte.
   always_comb begin
      q_group.b0      = (cnt == 2'd0) ? req_data_byte : held0_ff;
      q_group.b1      = (cnt == 2'd1) ? req_data_byte :
                        ((cnt == 2'd2) ? held1_ff : 8'd0);
      q_group.b2      = (cnt == 2'd2) ? req_data_byte : 8'd0;
      q_group.present = cnt + 2'd1;
   end

   // Store the byte while the group is still open.
   always_comb begin
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      held_count_in = held_count_ff;
      if (accept) begin
         if (closes) begin
            held_count_in = 2'd0;
         end else begin
            held_count_in = cnt + 2'd1;
            if (cnt == 2'd0) begin
               held0_in = req_data_byte;
            end else begin
               held1_in = req_data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      if (reset) begin
         held_count_ff <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
      end
   end

endmodule

[src/b64e_queue.sv]
// Short queue of finished groups between the front and the back.
// Two entries with read and write pointers and a fill count.
// Depends on b64e_pkg.
module b64e_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  b64e_pkg::group_type         push_group,
   output b64e_pkg::queue_status_type  status,
   input  logic                        pop,
   output b64e_pkg::group_type         head
);

   localparam int PtrW = $clog2(b64e_pkg::QueueDepth);
   localparam int CntW = $clog2(b64e_pkg::QueueDepth + 1);

   b64e_pkg::group_type entry_ff [b64e_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            do_push;
   logic            do_pop;

   assign status.full  = (fill_ff == CntW'(b64e_pkg::QueueDepth));
   assign status.empty = (fill_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(b64e_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(b64e_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[src/b64e_back.sv]
// Back part of the Base64 encoder: turns each queued group into four characters.
// Walks a character index and drives the registered response channel.
// Depends on b64e_pkg.
module b64e_back (
   input  logic                        clock,
   input  logic                        reset,
   input  b64e_pkg::queue_status_type  q_status,
   input  b64e_pkg::group_type         q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_group_end
);

   b64e_pkg::group_type group_ff, group_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       group_end_ff, group_end_in;
   logic       can_load;
   logic       load;
   logic       last_load;
   logic [5:0] sextet;
   logic       is_pad;

   // The output register can take a character when empty or being drained.
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign load      = busy_ff && can_load;
   assign last_load = load && (idx_ff == b64e_pkg::LastIdx);
   assign q_pop     = !q_status.empty && (!busy_ff || last_load);

   // Select the sextet for the current character index.
   always_comb begin
      case (idx_ff)
         2'd0: sextet = group_ff.b0[7:2];
         2'd1: sextet = {group_ff.b0[1:0], group_ff.b1[7:4]};
         2'd2: sextet = {group_ff.b1[3:0], group_ff.b2[7:6]};
         2'd3: sextet = group_ff.b2[5:0];
         default: sextet = '0;
      endcase
   end

   // Positions past the real bytes plus one are padding.
   assign is_pad = ({1'b0, idx_ff} > {1'b0, group_ff.present});

   // Group sequencing and output register next values.
   always_comb begin
      group_in     = group_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      out_char_in  = out_char_ff;
      group_end_in = group_end_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         out_char_in  = is_pad ? b64e_pkg::PadChar : b64e_pkg::sextet_char(sextet);
         group_end_in = (idx_ff == b64e_pkg::LastIdx);
         idx_in       = idx_ff + 2'd1;
      end else if (can_load) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         group_in = q_head;
         busy_in  = 1'b1;
         idx_in   = 2'd0;
      end else if (last_load) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      group_ff     <= group_in;
      out_char_ff  <= out_char_in;
      group_end_ff <= group_end_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_group_end = group_end_ff;

   // The fourth character of a group always carries the group end mark.
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      last_load |=> (rsp_valid_ff && group_end_ff))
      else $error("group end missing on last character");

   // The first two characters of a group are never padding.
   a_no_early_pad: assert property (@(posedge clock) disable iff (reset)
      (load && (idx_ff == 2'd0 || idx_ff == 2'd1)) |=>
      (out_char_ff != b64e_pkg::PadChar))
      else $error("pad in first two characters");

   // The unit only goes idle right after emitting the last character.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(last_load))
      else $error("group dropped before its last character");

endmodule

[src/base64_stream_encoder_unit.sv]
// Base64 stream encoder top level (standard alphabet, '=' padding).
// Instantiates b64e_front, b64e_queue and b64e_back; depends on b64e_pkg.
//
// Usage:
//   Request channel: one raw byte per request with an end-of-message flag.
//   A byte is taken at a clock edge with req_valid high and req_stall low.
//   Response channel: one ASCII character per beat; rsp_group_end marks the
//   fourth character of each group. The sender holds a beat while stalled.
//   Every three bytes, or the last byte of a message, produce four characters;
//   a short group ends in one or two '=' pads. Empty messages produce nothing.
// Path: a closing byte's group is written into the queue, then loaded into
//   the back end's group register; characters leave via the output register.
// Throughput: the back end emits one character per cycle while the receiver
//   does not stall and a group is waiting. A two-group queue lets the front
//   keep taking bytes while the back end drains.
// Stall: when the receiver stalls, the output register holds its character;
//   once the queue fills, req_stall rises until a group leaves it.
// Reset: synchronous, active high; clears the held byte count, the queue and
//   the output valid. No clearing pass is needed.
module base64_stream_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_group_end
);

   b64e_pkg::queue_status_type q_status;
   b64e_pkg::group_type        push_group;
   b64e_pkg::group_type        head_group;
   logic                       q_push;
   logic                       q_pop;

   // Front: byte collection and grouping.
   b64e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_is_final  (req_is_final),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_group       (push_group)
   );

   // Group queue between the two halves.
   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_group (push_group),
      .status     (q_status),
      .pop        (q_pop),
      .head       (head_group)
   );

   // Back: character generation and response register.
   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_head        (head_group),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_group_end (rsp_group_end)
   );

endmodule

[tb/sv/base64_stream_encoder_unit_test.sv]
// Self-checking testbench for the Base64 stream encoder top level.
// Drives byte requests with random idling and stalls, predicts every character and compares.
// Depends on b64e_pkg and base64_stream_encoder_unit.
module base64_stream_encoder_unit_test;

   // Standard alphabet, first character in the top byte.
   localparam logic [511:0] Base64Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int StuckLimit = 2000;
   localparam int HoldCycles = 80;
   localparam int DrainCycles = 12;

   typedef struct {
      logic [7:0] data_byte;
      logic       is_final;
   } byte_request_type;

   typedef struct {
      logic [7:0] out_char;
      logic       group_end;
   } encoded_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_is_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_group_end;

   byte_request_type pending_bytes[$];
   encoded_char_type expected_chars[$];

   // Predictor state: the bytes of the group still open.
   logic [7:0] open_group[2];
   logic [1:0] open_count = 2'd0;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_request = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;
   logic req_taken = 1'b0;
   int   stuck_cycles = 0;
   int   error_count = 0;
   int   bytes_sent = 0;
   int   chars_checked = 0;
   int   short_groups = 0;
   int   messages_queued = 0;

   base64_stream_encoder_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_is_final  (req_is_final),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_group_end (rsp_group_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Update the open group for one byte and queue the characters it releases.
   task automatic encode_byte(input logic [7:0] data_byte, input logic is_final);
      logic [23:0] triple;
      logic [5:0]  sextet;
      logic [7:0]  chars[4];
      encoded_char_type ec;
      begin
         if (open_count < 2'd2 && !is_final) begin
            open_group[open_count[0]] = data_byte;
            open_count = open_count + 2'd1;
         end else begin
            // Missing bytes of a short group count as zero.
            case (open_count)
               2'd0: triple = {data_byte, 16'h0000};
               2'd1: triple = {open_group[0], data_byte, 8'h00};
               default: triple = {open_group[0], open_group[1], data_byte};
            endcase
            for (int k = 0; k < 4; k++) begin
               sextet = triple[23 - 6 * k -: 6];
               chars[k] = Base64Alphabet[8 * (63 - sextet) +: 8];
            end
            if (open_count < 2'd2) begin
               chars[3] = b64e_pkg::PadChar;
               short_groups++;
            end
            if (open_count == 2'd0) begin
               chars[2] = b64e_pkg::PadChar;
            end
            for (int k = 0; k < 4; k++) begin
               ec.out_char = chars[k];
               ec.group_end = (k == 3);
               expected_chars.push_back(ec);
            end
            open_count = 2'd0;
         end
      end
   endtask

   // Queue one message, the final flag on its last byte.
   task automatic queue_message(input logic [7:0] msg[$]);
      byte_request_type br;
      begin
         for (int i = 0; i < msg.size(); i++) begin
            br.data_byte = msg[i];
            br.is_final = (i == msg.size() - 1);
            pending_bytes.push_back(br);
         end
         messages_queued++;
      end
   endtask

   // Queue random messages until at least the given number of bytes is queued.
   task automatic queue_random_messages(input int byte_budget);
      logic [7:0] msg[$];
      int         len;
      int         pick;
      begin
         while (byte_budget > 0) begin
            msg.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(9, 1);
            for (int i = 0; i < len; i++) begin
               pick = $urandom_range(7);
               msg.push_back(pick == 0 ? 8'h00 : (pick == 1 ? 8'hFF : 8'($urandom())));
            end
            queue_message(msg);
            byte_budget -= len;
         end
      end
   endtask

   task automatic wait_all_sent();
      begin
         while (pending_bytes.size() != 0 || req_valid) begin
            @(posedge clock);
         end
      end
   endtask

   // Sender: present the next request at the falling edge, hold it while stalled.
   always @(negedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (req_valid && req_taken) begin
            void'(pending_bytes.pop_front());
         end
         offer = pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct;
         if (offer) begin
            req_data_byte <= pending_bytes[0].data_byte;
            req_is_final <= pending_bytes[0].is_final;
         end
         req_valid <= offer;
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HoldCycles - 1;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !reset && $urandom_range(99) < recv_stall_pct;
      end
   end

   // Monitor: take requests into the predictor and check each response.
   always @(posedge clock) begin
      encoded_char_type ec;
      logic req_fire;
      logic rsp_fire;
      if (!reset) begin
         req_fire = req_valid && !req_stall;
         rsp_fire = rsp_valid && !rsp_stall;
         req_taken <= req_fire;
         if (req_fire) begin
            encode_byte(req_data_byte, req_is_final);
            bytes_sent++;
         end
         if (rsp_fire) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected response: out_char %h group_end %b",
                      rsp_out_char, rsp_group_end);
               error_count++;
            end else begin
               ec = expected_chars.pop_front();
               if (rsp_out_char !== ec.out_char) begin
                  $error("out_char: expected %h, actual %h", ec.out_char, rsp_out_char);
                  error_count++;
               end
               if (rsp_group_end !== ec.group_end) begin
                  $error("group_end: expected %b, actual %b", ec.group_end, rsp_group_end);
                  error_count++;
               end
               chars_checked++;
            end
         end
         // Watchdog on cycles with no handshake on either side.
         if (req_fire || rsp_fire) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= StuckLimit) begin
            $display("base64_stream_encoder_unit: mismatch");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // Stimulus sequence.
   initial begin
      logic [7:0] msg[$];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: one-byte and two-byte final groups, extremes, full groups.
      msg = '{8'h00};                       queue_message(msg);
      msg = '{8'hFF};                       queue_message(msg);
      msg = '{8'hFF, 8'hFF};                queue_message(msg);
      msg = '{8'h00, 8'h00};                queue_message(msg);
      msg = '{8'h4D, 8'h61, 8'h6E};         queue_message(msg);
      msg = '{8'hFF, 8'hFF, 8'hFF};         queue_message(msg);
      msg = '{8'h00, 8'h00, 8'h00, 8'hFB};  queue_message(msg);
      msg = '{8'hAA, 8'h55, 8'h0F, 8'hF0, 8'hFE}; queue_message(msg);
      msg = '{8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61, 8'h6E}; queue_message(msg);
      wait_all_sent();

      // Random phases: receiver stalls more, then sender idles more, then neither.
      send_idle_pct = 36;
      recv_stall_pct = 70;
      queue_random_messages(65);
      wait_all_sent();
      send_idle_pct = 70;
      recv_stall_pct = 36;
      queue_random_messages(65);
      wait_all_sent();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_random_messages(65);
      // Long receiver hold-off while requests keep coming, to back up the queue.
      hold_request = 1'b1;
      wait_all_sent();

      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      $display("Encoded %0d bytes in %0d messages; checked %0d characters, %0d padded groups.",
               bytes_sent, messages_queued, chars_checked, short_groups);
      if (error_count == 0) begin
         $display("base64_stream_encoder_unit: match");
      end else begin
         $display("base64_stream_encoder_unit: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder_unit.sv
tb/sv/base64_stream_encoder_unit_test.sv
